### rtl/ppmir_pkg.sv
// Shared types, command codes, register indexes and reset values for the
// pulse-position infrared frame sender. No dependencies.
`timescale 1ns / 1ps

package ppmir_pkg;

  localparam int FRAME_BYTES_DEF = 255;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int TIME_W     = 20;
  localparam int REP_W      = 8;
  localparam int GAP_W      = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BURST     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_SYM0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_SYM1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_SYM2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_SYM3  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_GAP = 3'd6;

  // register reset values
  localparam logic [TIME_W-1:0] BURST_RST     = 20'd10082;
  localparam logic [TIME_W-1:0] GAP_SYM0_RST  = 20'd15122;
  localparam logic [TIME_W-1:0] GAP_SYM1_RST  = 20'd60481;
  localparam logic [TIME_W-1:0] GAP_SYM2_RST  = 20'd30238;
  localparam logic [TIME_W-1:0] GAP_SYM3_RST  = 20'd45359;
  localparam logic [REP_W-1:0]  REPEAT_RST    = 8'd0;
  localparam logic [GAP_W-1:0]  FRAME_GAP_RST = 32'd0;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'b00001,
    PH_BURST     = 5'b00010,
    PH_GAP       = 5'b00100,
    PH_FINAL     = 5'b01000,
    PH_FRAMEGAP  = 5'b10000
  } phase_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic mem_read;
    logic exec;
  } ctrl_cmd_t;

endpackage

### rtl/ppmir_ctrl.sv
// Word sequencer for the frame sender: capture, store read, update.
// Depends on ppmir_pkg.
`timescale 1ns / 1ps

module ppmir_ctrl
  import ppmir_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  output ctrl_cmd_t ctrl
);

  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_READ = 3'b010,
    C_EXEC = 3'b100
  } ctl_state_e;

  ctl_state_e state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      C_IDLE: begin
        if (start) state_next = C_READ;
      end
      C_READ:  state_next = C_EXEC;
      C_EXEC:  state_next = C_IDLE;
      default: state_next = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy          = (state != C_IDLE);
  assign ctrl.capture  = (state == C_IDLE) && start;
  assign ctrl.mem_read = (state == C_READ);
  assign ctrl.exec     = (state == C_EXEC);

endmodule

### rtl/ppmir_dp.sv
// Datapath of the frame sender: config registers, frame store, symbol timers
// and result registers. Depends on ppmir_pkg.
`timescale 1ns / 1ps

module ppmir_dp
  import ppmir_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             ctrl,
  input  logic [1:0]            command,
  input  logic [7:0]            byte_value,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  strobe,
  output logic                  carrier_gate,
  output logic                  busy_res,
  output logic                  accepted,
  output logic                  done_res
);

  localparam int ADDR_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int LEN_W  = $clog2(FRAME_BYTES + 1);

  // configuration
  logic [TIME_W-1:0] burst_ticks;
  logic [TIME_W-1:0] gap_ticks [4];
  logic [REP_W-1:0]  repeat_count;
  logic [GAP_W-1:0]  frame_gap_ticks;

  // captured word
  cmd_e       cmd_q;
  logic [7:0] byte_q;

  // frame store
  logic [7:0] mem [FRAME_BYTES];
  logic [7:0] rdata;
  logic       mem_we;

  // send state
  logic [LEN_W-1:0] frame_length, frame_length_next;
  logic [LEN_W-1:0] byte_position, byte_position_next;
  logic [1:0]       symbol_position, symbol_position_next;
  phase_e           phase, phase_next;
  logic [GAP_W-1:0] tick_count, tick_count_next;
  logic [REP_W-1:0] repeats_sent, repeats_sent_next;
  logic             acc, done;

  logic             sending;
  logic [GAP_W-1:0] cnt_inc;
  logic [GAP_W-1:0] burst_lim;
  logic [GAP_W-1:0] gap_lim;
  logic [7:0]       cur_byte;
  logic [7:0]       sym_shift;
  logic [LEN_W-1:0] bpos_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_ticks     <= BURST_RST;
      gap_ticks[0]    <= GAP_SYM0_RST;
      gap_ticks[1]    <= GAP_SYM1_RST;
      gap_ticks[2]    <= GAP_SYM2_RST;
      gap_ticks[3]    <= GAP_SYM3_RST;
      repeat_count    <= REPEAT_RST;
      frame_gap_ticks <= FRAME_GAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BURST:     burst_ticks     <= cfg_data[TIME_W-1:0];
        CFG_GAP_SYM0:  gap_ticks[0]    <= cfg_data[TIME_W-1:0];
        CFG_GAP_SYM1:  gap_ticks[1]    <= cfg_data[TIME_W-1:0];
        CFG_GAP_SYM2:  gap_ticks[2]    <= cfg_data[TIME_W-1:0];
        CFG_GAP_SYM3:  gap_ticks[3]    <= cfg_data[TIME_W-1:0];
        CFG_REPEAT:    repeat_count    <= cfg_data[REP_W-1:0];
        CFG_FRAME_GAP: frame_gap_ticks <= cfg_data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_q  <= cmd_e'(command);
      byte_q <= byte_value;
    end
  end

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[frame_length[ADDR_W-1:0]] <= byte_q;
    end
    if (ctrl.mem_read) begin
      rdata <= mem[byte_position[ADDR_W-1:0]];
    end
  end

  assign sending   = (phase != PH_IDLE);
  assign cnt_inc   = tick_count + GAP_W'(1);
  assign burst_lim = GAP_W'(burst_ticks);
  assign cur_byte  = (byte_position < frame_length) ? rdata : 8'd0;
  assign sym_shift = cur_byte >> {symbol_position, 1'b0};
  assign gap_lim   = GAP_W'(gap_ticks[sym_shift[1:0]]);
  assign bpos_step = byte_position + LEN_W'(1);

  always_comb begin
    frame_length_next    = frame_length;
    byte_position_next   = byte_position;
    symbol_position_next = symbol_position;
    phase_next           = phase;
    tick_count_next      = tick_count;
    repeats_sent_next    = repeats_sent;
    acc                  = 1'b0;
    done                 = 1'b0;
    mem_we               = 1'b0;
    if (ctrl.exec) begin
      case (cmd_q)
        CMD_LOAD: begin
          if (!sending && (frame_length < LEN_W'(FRAME_BYTES))) begin
            mem_we            = 1'b1;
            frame_length_next = frame_length + LEN_W'(1);
            acc               = 1'b1;
          end
        end
        CMD_START: begin
          if (!sending && (frame_length != '0)) begin
            repeats_sent_next    = '0;
            byte_position_next   = '0;
            symbol_position_next = '0;
            tick_count_next      = '0;
            phase_next           = PH_BURST;
            acc                  = 1'b1;
          end
        end
        CMD_TICK: begin
          case (phase)
            PH_IDLE: ;
            PH_BURST: begin
              if (cnt_inc >= burst_lim) begin
                phase_next      = PH_GAP;
                tick_count_next = '0;
              end else begin
                tick_count_next = cnt_inc;
              end
            end
            PH_GAP: begin
              if (cnt_inc >= gap_lim) begin
                tick_count_next = '0;
                if (symbol_position == 2'd3) begin
                  symbol_position_next = '0;
                  byte_position_next   = bpos_step;
                  phase_next = (bpos_step >= frame_length) ? PH_FINAL : PH_BURST;
                end else begin
                  symbol_position_next = symbol_position + 2'd1;
                  phase_next = (byte_position >= frame_length) ? PH_FINAL : PH_BURST;
                end
              end else begin
                tick_count_next = cnt_inc;
              end
            end
            PH_FINAL: begin
              if (cnt_inc >= burst_lim) begin
                tick_count_next = '0;
                if (repeats_sent >= repeat_count) begin
                  phase_next           = PH_IDLE;
                  repeats_sent_next    = '0;
                  byte_position_next   = '0;
                  symbol_position_next = '0;
                  done                 = 1'b1;
                end else begin
                  repeats_sent_next = repeats_sent + REP_W'(1);
                  if (frame_gap_ticks != '0) begin
                    phase_next = PH_FRAMEGAP;
                  end else begin
                    byte_position_next   = '0;
                    symbol_position_next = '0;
                    phase_next           = PH_BURST;
                  end
                end
              end else begin
                tick_count_next = cnt_inc;
              end
            end
            PH_FRAMEGAP: begin
              if (cnt_inc >= frame_gap_ticks) begin
                byte_position_next   = '0;
                symbol_position_next = '0;
                tick_count_next      = '0;
                phase_next           = PH_BURST;
              end else begin
                tick_count_next = cnt_inc;
              end
            end
            default: begin
              phase_next      = PH_IDLE;
              tick_count_next = '0;
            end
          endcase
        end
        CMD_CLEAR: begin
          if (!sending) begin
            frame_length_next    = '0;
            byte_position_next   = '0;
            symbol_position_next = '0;
            acc                  = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length    <= '0;
      byte_position   <= '0;
      symbol_position <= '0;
      phase           <= PH_IDLE;
      tick_count      <= '0;
      repeats_sent    <= '0;
      strobe          <= 1'b0;
    end else begin
      frame_length    <= frame_length_next;
      byte_position   <= byte_position_next;
      symbol_position <= symbol_position_next;
      phase           <= phase_next;
      tick_count      <= tick_count_next;
      repeats_sent    <= repeats_sent_next;
      strobe          <= ctrl.exec;
    end
  end

  // result word, shown for one cycle with strobe
  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      carrier_gate <= (phase_next == PH_BURST) || (phase_next == PH_FINAL);
      busy_res     <= (phase_next != PH_IDLE);
      accepted     <= acc;
      done_res     <= done;
    end
  end

endmodule

### rtl/ppm_ir_frame_transmitter.sv
// Top level of the pulse-position infrared frame sender: sequencer plus
// datapath. Depends on ppmir_pkg, ppmir_ctrl and ppmir_dp.
//
//   channel   ports                                        handshake
//   input     command, byte_value                          start & !busy
//   result    carrier_gate, busy_res, accepted, done_res   strobe, one cycle
//   config    cfg_index, cfg_data                          cfg_we
//
// Each word passes through capture, frame store read and state update in turn;
// the registered frame store read adds the read step. The result is shown with
// strobe high in the cycle after the update, and the next word can be taken
// in that same cycle. The receiver cannot stall. Synchronous reset returns
// the sender to idle with an empty store and default register values.
`timescale 1ns / 1ps

module ppm_ir_frame_transmitter
  import ppmir_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            command,
  input  logic [7:0]            byte_value,
  output logic                  strobe,
  output logic                  carrier_gate,
  output logic                  busy_res,
  output logic                  accepted,
  output logic                  done_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t ctrl;

  ppmir_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  ppmir_dp #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .command      (command),
    .byte_value   (byte_value),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .strobe       (strobe),
    .carrier_gate (carrier_gate),
    .busy_res     (busy_res),
    .accepted     (accepted),
    .done_res     (done_res)
  );

endmodule

### test/ppm_ir_frame_transmitter_tb.sv
// Self-checking testbench for the pulse-position infrared frame sender.
// Depends on ppmir_pkg and ppm_ir_frame_transmitter; every word is predicted
// in the testbench and every strobed result is checked in order.
`timescale 1ns / 1ps

module ppm_ir_frame_transmitter_tb;
  import ppmir_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic carrier;
    logic sending;
    logic accepted;
    logic done;
  } ir_result_t;

  // field order: carrier, sending, accepted, done
  localparam ir_result_t R_IDLE     = 4'b0000;
  localparam ir_result_t R_TAKEN    = 4'b0010;
  localparam ir_result_t R_LAUNCH   = 4'b1110;
  localparam ir_result_t R_BURST_ON = 4'b1100;
  localparam ir_result_t R_GAP      = 4'b0100;
  localparam ir_result_t R_DONE     = 4'b0001;

  typedef struct packed {
    logic                  is_reg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    cmd_e                  cmd;
    logic [7:0]            val;
    logic                  typed;
    ir_result_t            want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            command = CMD_TICK;
  logic [7:0]            byte_value = 8'h00;
  logic                  strobe;
  logic                  carrier_gate;
  logic                  busy_res;
  logic                  accepted;
  logic                  done_res;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_BURST;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ppm_ir_frame_transmitter uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .byte_value(byte_value),
    .strobe(strobe),
    .carrier_gate(carrier_gate),
    .busy_res(busy_res),
    .accepted(accepted),
    .done_res(done_res),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // sender shadow state
  logic [7:0]        store_mem [FRAME_BYTES_DEF];
  logic [7:0]        frame_len = '0;
  logic [7:0]        byte_pos = '0;
  logic [1:0]        symbol_pos = '0;
  phase_e            tx_phase = PH_IDLE;
  logic [31:0]       tick_cnt = '0;
  logic [7:0]        repeats_done = '0;
  logic [TIME_W-1:0] burst_len = BURST_RST;
  logic [TIME_W-1:0] gap_len [4] = '{GAP_SYM0_RST, GAP_SYM1_RST, GAP_SYM2_RST, GAP_SYM3_RST};
  logic [REP_W-1:0]  repeat_len = REPEAT_RST;
  logic [GAP_W-1:0]  frame_gap_len = FRAME_GAP_RST;

  ir_result_t pending_results[$];
  int mismatches = 0;
  int words_sent = 0;
  int results_seen = 0;
  int reg_writes = 0;
  int cycle_cnt = 0;
  int idle_pct = 0;

  always #1 clk = ~clk;

  function automatic void restart_frame();
    byte_pos = '0;
    symbol_pos = '0;
    tick_cnt = '0;
    tx_phase = PH_BURST;
  endfunction

  // one tick of the symbol timers; returns 1 when the whole sequence ends
  function automatic logic advance_tick();
    logic [7:0] cur;
    logic [1:0] sym;
    if (tx_phase == PH_IDLE) return 1'b0;
    tick_cnt++;
    case (tx_phase)
      PH_BURST: begin
        if (tick_cnt >= burst_len) begin
          tx_phase = PH_GAP;
          tick_cnt = '0;
        end
      end
      PH_GAP: begin
        cur = (byte_pos < frame_len) ? store_mem[byte_pos] : 8'h00;
        sym = cur[{symbol_pos, 1'b0} +: 2];
        if (tick_cnt >= gap_len[sym]) begin
          tick_cnt = '0;
          if (symbol_pos == 2'd3) begin
            symbol_pos = '0;
            byte_pos++;
          end else begin
            symbol_pos++;
          end
          tx_phase = (byte_pos >= frame_len) ? PH_FINAL : PH_BURST;
        end
      end
      PH_FINAL: begin
        if (tick_cnt >= burst_len) begin
          tick_cnt = '0;
          if (repeats_done >= repeat_len) begin
            tx_phase = PH_IDLE;
            repeats_done = '0;
            byte_pos = '0;
            symbol_pos = '0;
            return 1'b1;
          end
          repeats_done++;
          if (frame_gap_len != 0) tx_phase = PH_FRAMEGAP;
          else restart_frame();
        end
      end
      PH_FRAMEGAP: begin
        if (tick_cnt >= frame_gap_len) restart_frame();
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic ir_result_t predict_word(cmd_e cmd, logic [7:0] val);
    ir_result_t r;
    logic       was_busy;
    was_busy = (tx_phase != PH_IDLE);
    r = '0;
    case (cmd)
      CMD_LOAD: begin
        if (!was_busy && frame_len < FRAME_BYTES_DEF) begin
          store_mem[frame_len] = val;
          frame_len++;
          r.accepted = 1'b1;
        end
      end
      CMD_START: begin
        if (!was_busy && frame_len != 0) begin
          repeats_done = '0;
          restart_frame();
          r.accepted = 1'b1;
        end
      end
      CMD_TICK: r.done = advance_tick();
      default: begin
        if (!was_busy) begin
          frame_len = '0;
          byte_pos = '0;
          symbol_pos = '0;
          r.accepted = 1'b1;
        end
      end
    endcase
    r.carrier = (tx_phase == PH_BURST || tx_phase == PH_FINAL);
    r.sending = (tx_phase != PH_IDLE);
    return r;
  endfunction

  // a typed expectation replaces the predicted one, the shadow state still advances
  task automatic send_word(cmd_e cmd, logic [7:0] val, logic typed, ir_result_t want);
    ir_result_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    byte_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = predict_word(cmd, val);
    pending_results.push_back(typed ? want : predicted);
    words_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_BURST:     burst_len = data[TIME_W-1:0];
      CFG_GAP_SYM0:  gap_len[0] = data[TIME_W-1:0];
      CFG_GAP_SYM1:  gap_len[1] = data[TIME_W-1:0];
      CFG_GAP_SYM2:  gap_len[2] = data[TIME_W-1:0];
      CFG_GAP_SYM3:  gap_len[3] = data[TIME_W-1:0];
      CFG_REPEAT:    repeat_len = data[REP_W-1:0];
      CFG_FRAME_GAP: frame_gap_len = data[GAP_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_timing(int unsigned burst, int unsigned g0, int unsigned g1,
                            int unsigned g2, int unsigned g3, int unsigned rep,
                            logic [31:0] fgap);
    write_reg(CFG_BURST, burst);
    write_reg(CFG_GAP_SYM0, g0);
    write_reg(CFG_GAP_SYM1, g1);
    write_reg(CFG_GAP_SYM2, g2);
    write_reg(CFG_GAP_SYM3, g3);
    write_reg(CFG_REPEAT, rep);
    write_reg(CFG_FRAME_GAP, fgap);
  endtask

  task automatic random_timing();
    // zero lengths show up now and then, they must behave as one tick
    set_timing(($urandom_range(3) == 0) ? 0 : $urandom_range(1, 2),
               $urandom_range(0, 3), $urandom_range(0, 3),
               $urandom_range(0, 3), $urandom_range(0, 3),
               ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0,
               $urandom_range(1) ? $urandom_range(1, 3) : 0);
  endtask

  task automatic tick_until_idle();
    while (tx_phase != PH_IDLE) send_word(CMD_TICK, 8'($urandom), 1'b0, R_IDLE);
  endtask

  task automatic random_sequence();
    int nbytes;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 6))
        send_word(cmd_e'($urandom_range(3)), 8'($urandom), 1'b0, R_IDLE);
    end else begin
      if ($urandom_range(99) < 20) random_timing();
      if ($urandom_range(99) < 70 || frame_len > 8)
        send_word(CMD_CLEAR, 8'($urandom), 1'b0, R_IDLE);
      nbytes = $urandom_range(1, 2);
      repeat (nbytes) send_word(CMD_LOAD, 8'($urandom), 1'b0, R_IDLE);
      send_word(CMD_START, 8'($urandom), 1'b0, R_IDLE);
      // mostly ticks, with stray commands that a busy sender must refuse
      while (tx_phase != PH_IDLE)
        send_word(($urandom_range(99) < 8) ? cmd_e'($urandom_range(3)) : CMD_TICK,
                  8'($urandom), 1'b0, R_IDLE);
    end
  endtask

  function automatic stim_row_t word_row(cmd_e cmd, logic [7:0] val, logic typed,
                                         ir_result_t want);
    stim_row_t r;
    r = '0;
    r.cmd = cmd;
    r.val = val;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r = '0;
    r.is_reg = 1'b1;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  always @(posedge clk) begin : result_check
    ir_result_t got;
    ir_result_t want;
    if (!rst && strobe) begin
      got = {carrier_gate, busy_res, accepted, done_res};
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, got carrier=%b busy=%b accepted=%b done=%b",
                 $time, got.carrier, got.sending, got.accepted, got.done);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: mismatch, expected carrier=%b busy=%b accepted=%b done=%b",
                   $time, want.carrier, want.sending, want.accepted, want.done);
          $display("%0t:           actual carrier=%b busy=%b accepted=%b done=%b",
                   $time, got.carrier, got.sending, got.accepted, got.done);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words outstanding", $time, pending_results.size());
      $display("ppm_ir_frame_transmitter_tb failed");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    int        target;

    // reset timing, empty store and refusals
    rows.push_back(word_row(CMD_TICK,  8'h00, 1'b1, R_IDLE));
    rows.push_back(word_row(CMD_START, 8'hFF, 1'b1, R_IDLE));
    rows.push_back(word_row(CMD_LOAD,  8'h00, 1'b1, R_TAKEN));
    rows.push_back(word_row(CMD_LOAD,  8'hFF, 1'b1, R_TAKEN));
    rows.push_back(word_row(CMD_CLEAR, 8'h00, 1'b1, R_TAKEN));
    rows.push_back(word_row(CMD_START, 8'h00, 1'b1, R_IDLE));
    // symbols 0, 1, 2, 3 in sending order
    rows.push_back(word_row(CMD_LOAD,  8'hE4, 1'b1, R_TAKEN));
    rows.push_back(reg_row(CFG_BURST, 32'hFFFF_FFFF));
    rows.push_back(word_row(CMD_START, 8'h00, 1'b1, R_LAUNCH));
    rows.push_back(word_row(CMD_LOAD,  8'h5A, 1'b1, R_BURST_ON));
    rows.push_back(word_row(CMD_START, 8'h00, 1'b1, R_BURST_ON));
    rows.push_back(word_row(CMD_CLEAR, 8'h00, 1'b1, R_BURST_ON));
    rows.push_back(word_row(CMD_TICK,  8'h00, 1'b1, R_BURST_ON));
    // shorten the running burst to zero, upper data bits must be dropped
    rows.push_back(reg_row(CFG_BURST, 32'hFFF0_0000));
    rows.push_back(reg_row(CFG_GAP_SYM0, 32'd0));
    rows.push_back(reg_row(CFG_GAP_SYM1, 32'd1));
    rows.push_back(reg_row(CFG_GAP_SYM2, 32'h0010_0001));
    rows.push_back(reg_row(CFG_GAP_SYM3, 32'd2));
    rows.push_back(reg_row(CFG_UNUSED, 32'hFFFF_FFFF));
    rows.push_back(word_row(CMD_TICK, 8'h00, 1'b1, R_GAP));
    repeat (8) rows.push_back(word_row(CMD_TICK, 8'h00, 1'b0, R_IDLE));
    rows.push_back(word_row(CMD_TICK, 8'h00, 1'b1, R_DONE));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].is_reg) write_reg(rows[i].idx, rows[i].data);
      else send_word(rows[i].cmd, rows[i].val, rows[i].typed, rows[i].want);
    end

    // fill the store to the last entry, one more load must be refused
    send_word(CMD_CLEAR, 8'($urandom), 1'b0, R_IDLE);
    repeat (FRAME_BYTES_DEF) send_word(CMD_LOAD, 8'($urandom), 1'b0, R_IDLE);
    send_word(CMD_LOAD, 8'($urandom), 1'b0, R_IDLE);
    send_word(CMD_CLEAR, 8'($urandom), 1'b0, R_IDLE);

    // several repeats, longest frame gap cut short while it runs
    idle_pct = 15;
    set_timing(1, 2, 1, 1, 1, 3, 32'hFFFF_FFFF);
    send_word(CMD_CLEAR, 8'($urandom), 1'b0, R_IDLE);
    send_word(CMD_LOAD, 8'($urandom), 1'b0, R_IDLE);
    send_word(CMD_START, 8'($urandom), 1'b0, R_IDLE);
    while (tx_phase != PH_FRAMEGAP) send_word(CMD_TICK, 8'($urandom), 1'b0, R_IDLE);
    repeat (3) send_word(CMD_TICK, 8'($urandom), 1'b0, R_IDLE);
    write_reg(CFG_FRAME_GAP, 32'd1);
    tick_until_idle();

    for (int p = 0; p < 3; p++) begin
      idle_pct = (p == 0) ? 0 : (p == 1) ? 60 : 15;
      random_timing();
      target = words_sent + 20;
      while (words_sent < target) random_sequence();
    end

    drain_results();
    repeat (10) @(posedge clk);
    $display("covered directed rows, a full store with a refused load, repeats with a gap");
    $display("change mid-send and three sender idle profiles: %0d words, %0d results, %0d writes",
             words_sent, results_seen, reg_writes);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ppm_ir_frame_transmitter_tb passed");
    end else begin
      $display("ppm_ir_frame_transmitter_tb failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/ppmir_pkg.sv
rtl/ppmir_ctrl.sv
rtl/ppmir_dp.sv
rtl/ppm_ir_frame_transmitter.sv
test/ppm_ir_frame_transmitter_tb.sv
